// File: design/cbor_enc_pkg.sv
// Shared types and constants for the CBOR item head encoder.
// No dependencies; imported by every module of the block.
package cbor_enc_pkg;

  localparam int unsigned ValueW      = 64;
  localparam int unsigned ByteW       = 8;
  localparam int unsigned MaxBytes    = 9;
  localparam int unsigned NbytesW     = 4;
  localparam int unsigned ShiftW      = MaxBytes * ByteW;
  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [ValueW-1:0] MaxInsitu = ValueW'(23);

  localparam logic [ByteW-1:0] IbTrue   = 8'hf5;
  localparam logic [ByteW-1:0] IbFalse  = 8'hf4;
  localparam logic [ByteW-1:0] IbNull   = 8'hf6;
  localparam logic [ByteW-1:0] IbDouble = 8'hfb;

  localparam logic [4:0] AiOne   = 5'd24;
  localparam logic [4:0] AiTwo   = 5'd25;
  localparam logic [4:0] AiFour  = 5'd26;
  localparam logic [4:0] AiEight = 5'd27;

  typedef enum logic [3:0] {
    OP_INT     = 4'd0,
    OP_BYTES   = 4'd1,
    OP_TEXT    = 4'd2,
    OP_ARRAY   = 4'd3,
    OP_MAP     = 4'd4,
    OP_BOOL    = 4'd5,
    OP_NULL    = 4'd6,
    OP_DOUBLE  = 4'd7,
    OP_PAYLOAD = 4'd8
  } op_e;

  typedef enum logic [2:0] {
    MT_UINT  = 3'd0,
    MT_NINT  = 3'd1,
    MT_BYTES = 3'd2,
    MT_TEXT  = 3'd3,
    MT_ARRAY = 3'd4,
    MT_MAP   = 3'd5
  } major_e;

  typedef struct packed {
    logic [3:0]        operation;
    logic [ValueW-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             last;
  } out_item_t;

  // Encoded token: bytes left-aligned, first byte in the top lane.
  typedef struct packed {
    logic [NbytesW-1:0] nbytes;
    logic [ShiftW-1:0]  bytes;
  } cmd_t;

endpackage

// File: design/cbor_enc_front.sv
// Front end: classifies an input token and builds its byte image.
// Depends on cbor_enc_pkg.
module cbor_enc_front (
  input  cbor_enc_pkg::in_item_t item_i,
  output logic                   cmd_vld_o,
  output cbor_enc_pkg::cmd_t     cmd_o
);
  import cbor_enc_pkg::*;

  logic                head;
  logic [2:0]          major;
  logic [ValueW-1:0]   arg;
  logic [ByteW-1:0]    ib;
  logic [ValueW-1:0]   body;
  logic [NbytesW-1:0]  nb;

  always_comb begin
    head      = 1'b0;
    major     = MT_UINT;
    arg       = item_i.value;
    ib        = '0;
    body      = '0;
    nb        = NbytesW'(1);
    cmd_vld_o = 1'b1;
    unique case (item_i.operation)
      OP_INT: begin
        head = 1'b1;
        if (item_i.value[ValueW-1]) begin
          major = MT_NINT;
          arg   = ~item_i.value;
        end
      end
      OP_BYTES: begin
        head  = 1'b1;
        major = MT_BYTES;
      end
      OP_TEXT: begin
        head  = 1'b1;
        major = MT_TEXT;
      end
      OP_ARRAY: begin
        head  = 1'b1;
        major = MT_ARRAY;
      end
      OP_MAP: begin
        head  = 1'b1;
        major = MT_MAP;
      end
      OP_BOOL:    ib = item_i.value[0] ? IbTrue : IbFalse;
      OP_NULL:    ib = IbNull;
      OP_DOUBLE: begin
        ib   = IbDouble;
        body = item_i.value;
        nb   = NbytesW'(9);
      end
      OP_PAYLOAD: ib = item_i.value[ByteW-1:0];
      default:    cmd_vld_o = 1'b0;
    endcase

    // shortest argument form, argument bytes left-aligned behind the initial byte
    if (head) begin
      if (arg <= MaxInsitu) begin
        ib = {major, arg[4:0]};
        nb = NbytesW'(1);
      end else if (arg[ValueW-1:8] == '0) begin
        ib   = {major, AiOne};
        body = {arg[7:0], 56'd0};
        nb   = NbytesW'(2);
      end else if (arg[ValueW-1:16] == '0) begin
        ib   = {major, AiTwo};
        body = {arg[15:0], 48'd0};
        nb   = NbytesW'(3);
      end else if (arg[ValueW-1:32] == '0) begin
        ib   = {major, AiFour};
        body = {arg[31:0], 32'd0};
        nb   = NbytesW'(5);
      end else begin
        ib   = {major, AiEight};
        body = arg;
        nb   = NbytesW'(9);
      end
    end

    cmd_o.nbytes = nb;
    cmd_o.bytes  = {ib, body};
  end

endmodule

// File: design/cbor_enc_queue.sv
// Small register queue between the classifier and the byte serializer.
// Depends on cbor_enc_pkg.
module cbor_enc_queue #(
  parameter int unsigned Depth = cbor_enc_pkg::QueueDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  cbor_enc_pkg::cmd_t wr_data_i,
  output logic               full_o,
  output logic               rd_vld_o,
  input  logic               rd_en_i,
  output cbor_enc_pkg::cmd_t rd_data_o
);
  import cbor_enc_pkg::*;

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam logic [CntW-1:0]  FullCnt  = CntW'(Depth);

  cmd_t             mem_q [Depth];
  logic [AddrW-1:0] wptr_q, wptr_d;
  logic [AddrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o    = (cnt_q == FullCnt);
  assign rd_vld_o  = (cnt_q != '0);
  assign rd_data_o = mem_q[rptr_q];
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && rd_vld_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_wr) begin
      wptr_d = (wptr_q == LastAddr) ? '0 : wptr_q + AddrW'(1);
    end
    if (do_rd) begin
      rptr_d = (rptr_q == LastAddr) ? '0 : rptr_q + AddrW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

endmodule

// File: design/cbor_enc_back.sv
// Back end: shifts out one encoded byte per cycle into the output register while that register is free or being popped.
// Depends on cbor_enc_pkg.
module cbor_enc_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cmd_vld_i,
  input  cbor_enc_pkg::cmd_t      cmd_i,
  output logic                    cmd_pop_o,
  output logic                    empty_o,
  input  logic                    pop_i,
  output cbor_enc_pkg::out_item_t out_item_o
);
  import cbor_enc_pkg::*;

  logic [ShiftW-1:0]  sh_q, sh_d;
  logic [NbytesW-1:0] rem_q, rem_d;
  logic               out_vld_q, out_vld_d;
  out_item_t          out_q, out_d;
  logic               adv, ld, cur_last;

  always_comb begin
    cur_last  = (rem_q == NbytesW'(1));
    // output slot is free or being drained this cycle
    adv       = (rem_q != '0) && (!out_vld_q || pop_i);
    ld        = cmd_vld_i && ((rem_q == '0) || (adv && cur_last));
    cmd_pop_o = ld;

    sh_d  = sh_q;
    rem_d = rem_q;
    if (ld) begin
      sh_d  = cmd_i.bytes;
      rem_d = cmd_i.nbytes;
    end else if (adv) begin
      sh_d  = {sh_q[ShiftW-ByteW-1:0], {ByteW{1'b0}}};
      rem_d = rem_q - NbytesW'(1);
    end

    out_d     = out_q;
    out_vld_d = out_vld_q;
    if (adv) begin
      out_d.out_byte = sh_q[ShiftW-1 -: ByteW];
      out_d.last     = cur_last;
      out_vld_d      = 1'b1;
    end else if (pop_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      rem_q     <= rem_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    out_q <= out_d;
  end

  assign empty_o    = !out_vld_q;
  assign out_item_o = out_q;

endmodule

// File: design/cbor_item_head_encoder_top.sv
// Top level of the CBOR item head encoder: classifier, queue, serializer.
// Depends on cbor_enc_pkg, cbor_enc_front, cbor_enc_queue, cbor_enc_back.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-----------------------------
//  input    | in        | push / full        | in_item_i  (operation, value)
//  result   | out       | empty / pop        | out_item_o (out_byte, last)
//
// Each token yields 1 to 9 bytes; the result side moves one byte per cycle while
// pop is held high.
// The first byte of an accepted token passes through the queue and the shift register into the output register.
// Unused operation codes are accepted and produce nothing.
// Reset empties the queue and the output register. Pop held low stalls only
// the serializer; the input keeps accepting until the queue fills.
module cbor_item_head_encoder_top #(
  parameter int unsigned QueueDepth = cbor_enc_pkg::QueueDepthDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push,
  output logic                    full,
  input  cbor_enc_pkg::in_item_t  in_item_i,
  output logic                    empty,
  input  logic                    pop,
  output cbor_enc_pkg::out_item_t out_item_o
);
  import cbor_enc_pkg::*;

  logic cmd_vld;
  cmd_t cmd;
  logic q_vld;
  cmd_t q_data;
  logic q_pop;

  cbor_enc_front u_front (
    .item_i    (in_item_i),
    .cmd_vld_o (cmd_vld),
    .cmd_o     (cmd)
  );

  cbor_enc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (push && cmd_vld),
    .wr_data_i (cmd),
    .full_o    (full),
    .rd_vld_o  (q_vld),
    .rd_en_i   (q_pop),
    .rd_data_o (q_data)
  );

  cbor_enc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_vld_i  (q_vld),
    .cmd_i      (q_data),
    .cmd_pop_o  (q_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_item_o (out_item_o)
  );

endmodule

// File: tb/sv/cbor_item_head_encoder_top_tb.sv
// Self-checking testbench for cbor_item_head_encoder_top: directed tokens, then random
// tokens, each byte checked against table bytes or an in-bench CBOR head encoder. Depends on cbor_enc_pkg.
module cbor_item_head_encoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cbor_enc_pkg::*;

  localparam int unsigned RandomTokens = 433;
  localparam int unsigned CalmTokens   = 60;
  localparam int unsigned HoldTrigger  = 60;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned DrainCycles  = 20;
  localparam int unsigned MaxPrinted   = 50;
  localparam longint unsigned TimeoutNs = 4_000_000;

  localparam logic [63:0] Max1Byte = 64'hff;
  localparam logic [63:0] Max2Byte = 64'hffff;
  localparam logic [63:0] Max4Byte = 64'hffff_ffff;

  localparam logic [3:0] OpUnusedLo = 4'd9;
  localparam logic [3:0] OpUnusedHi = 4'd15;

  // nref == 0: expected bytes come from encode_token; else ref_bytes, right-aligned.
  typedef struct {
    logic [3:0]  op;
    logic [63:0] val;
    int          nref;
    logic [71:0] ref_bytes;
  } token_vec_t;

  logic      clk_i;
  logic      rst_ni;
  logic      push;
  logic      full;
  in_item_t  in_item_i;
  logic      empty;
  logic      pop;
  out_item_t out_item_o;

  out_item_t   expected_bytes[$];
  int unsigned mismatches;
  int unsigned tokens_sent;
  bit          calm;

  token_vec_t directed_tokens[$] = '{
    '{OP_INT,      64'd0,                   1, 72'h00},
    '{OP_INT,      64'd23,                  1, 72'h17},
    '{OP_INT,      64'd24,                  2, 72'h18_18},
    '{OP_INT,      64'd255,                 0, 72'h0},
    '{OP_INT,      64'd256,                 0, 72'h0},
    '{OP_INT,      64'd65535,               0, 72'h0},
    '{OP_INT,      64'd65536,               0, 72'h0},
    '{OP_INT,      64'hffff_ffff,           0, 72'h0},
    '{OP_INT,      64'h1_0000_0000,         0, 72'h0},
    '{OP_INT,      64'h7fff_ffff_ffff_ffff, 9, 72'h1b_7fff_ffff_ffff_ffff},
    '{OP_INT,      64'h8000_0000_0000_0000, 9, 72'h3b_7fff_ffff_ffff_ffff},
    '{OP_INT,      64'hffff_ffff_ffff_ffff, 1, 72'h20},
    '{OP_INT,      64'hffff_ffff_ffff_ffe8, 1, 72'h37},
    '{OP_INT,      64'hffff_ffff_ffff_ffe7, 0, 72'h0},
    '{OP_BYTES,    64'd0,                   1, 72'h40},
    '{OP_TEXT,     64'd24,                  2, 72'h78_18},
    '{OP_ARRAY,    64'd65535,               0, 72'h0},
    '{OP_MAP,      64'hffff_ffff_ffff_ffff, 9, 72'hbb_ffff_ffff_ffff_ffff},
    '{OP_BOOL,     64'd1,                   1, 72'hf5},
    '{OP_BOOL,     64'hffff_ffff_ffff_fffe, 1, 72'hf4},
    '{OP_NULL,     64'hffff_ffff_ffff_ffff, 1, 72'hf6},
    '{OP_DOUBLE,   64'h3ff0_0000_0000_0000, 0, 72'h0},
    '{OP_DOUBLE,   64'hffff_ffff_ffff_ffff, 9, 72'hfb_ffff_ffff_ffff_ffff},
    '{OP_PAYLOAD,  64'hffff_ffff_ffff_ff00, 1, 72'h00},
    '{OP_PAYLOAD,  64'hab,                  0, 72'h0},
    '{OpUnusedLo,  64'hffff_ffff_ffff_ffff, 0, 72'h0},
    '{OpUnusedHi,  64'd0,                   0, 72'h0}
  };

  cbor_item_head_encoder_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    mismatches++;
    if (mismatches <= MaxPrinted) begin
      $display("%0t ns: %s mismatch, got %h expected %h", $time, what, got, want);
    end
  endtask

  // Queues the bytes one token should produce, shortest argument form.
  task automatic encode_token(input in_item_t it);
    logic [7:0]  token[$];
    logic [63:0] arg;
    logic [2:0]  major;
    logic [4:0]  ai;
    logic        is_head;
    int          nb;
    is_head = 1'b1;
    arg     = it.value;
    major   = MT_UINT;
    ai      = AiOne;
    nb      = 1;
    case (it.operation)
      OP_INT: begin
        if (it.value[63]) begin
          major = MT_NINT;
          arg   = ~it.value;
        end
      end
      OP_BYTES: major = MT_BYTES;
      OP_TEXT:  major = MT_TEXT;
      OP_ARRAY: major = MT_ARRAY;
      OP_MAP:   major = MT_MAP;
      default:  is_head = 1'b0;
    endcase
    if (is_head) begin
      if (arg <= MaxInsitu) begin
        token.push_back({major, arg[4:0]});
      end else begin
        if (arg <= Max1Byte) begin
          ai = AiOne;
          nb = 1;
        end else if (arg <= Max2Byte) begin
          ai = AiTwo;
          nb = 2;
        end else if (arg <= Max4Byte) begin
          ai = AiFour;
          nb = 4;
        end else begin
          ai = AiEight;
          nb = 8;
        end
        token.push_back({major, ai});
        for (int i = nb - 1; i >= 0; i--) token.push_back(arg[8*i +: 8]);
      end
    end else begin
      case (it.operation)
        OP_BOOL:    token.push_back(it.value[0] ? IbTrue : IbFalse);
        OP_NULL:    token.push_back(IbNull);
        OP_DOUBLE: begin
          token.push_back(IbDouble);
          for (int i = 7; i >= 0; i--) token.push_back(it.value[8*i +: 8]);
        end
        OP_PAYLOAD: token.push_back(it.value[7:0]);
        default: ;
      endcase
    end
    foreach (token[i]) begin
      expected_bytes.push_back('{out_byte: token[i], last: (i == token.size() - 1)});
    end
  endtask

  // Offers one item and returns at the edge that accepts it; push is left high.
  task automatic send_token(input in_item_t it);
    push      <= 1'b1;
    in_item_i <= it;
    forever begin
      @(negedge clk_i);
      if (!full) break;
    end
    @(posedge clk_i);
    tokens_sent++;
  endtask

  task automatic maybe_pause_sender();
    if (!calm && $urandom_range(0, 3) == 0) begin
      push      <= 1'b0;
      in_item_i <= {4'($urandom), $urandom, $urandom};
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  // Biased toward the boundaries between argument sizes.
  function automatic logic [63:0] rand_value();
    logic [63:0] wide;
    logic [63:0] edges [8];
    wide  = {$urandom, $urandom};
    edges = '{64'd23, 64'd24, Max1Byte, Max1Byte + 1, Max2Byte, Max2Byte + 1,
              Max4Byte, Max4Byte + 1};
    case ($urandom_range(0, 7))
      0: return 64'($urandom_range(0, 23));
      1: return 64'($urandom_range(24, 255));
      2: return 64'($urandom_range(256, 65535));
      3: return 64'(wide[31:0]);
      4: return edges[$urandom_range(0, 7)];
      5: return ~edges[$urandom_range(0, 7)];
      6: return ~64'($urandom_range(0, 300));
      default: return wide;
    endcase
  endfunction

  // Result side: the byte on the ports is taken at the next rising edge.
  always @(negedge clk_i) begin : byte_check
    out_item_t want;
    if (rst_ni && pop && !empty) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch("unexpected byte", out_item_o.out_byte, 8'h00);
      end else begin
        want = expected_bytes.pop_front();
        if (out_item_o.out_byte !== want.out_byte) begin
          report_mismatch("out_byte", out_item_o.out_byte, want.out_byte);
        end
        if (out_item_o.last !== want.last) begin
          report_mismatch("last", 8'(out_item_o.last), 8'(want.last));
        end
      end
    end
  end

  initial begin : receiver
    bit hold_done;
    hold_done = 1'b0;
    pop <= 1'b0;
    @(posedge clk_i iff rst_ni);
    forever begin
      if (!hold_done && tokens_sent >= HoldTrigger) begin
        // long stall so the queue fills and full backs up the input
        hold_done = 1'b1;
        pop <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end else begin
        pop <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    in_item_t   it;
    token_vec_t row;
    mismatches  = 0;
    tokens_sent = 0;
    calm        = 1'b0;
    rst_ni    <= 1'b0;
    push      <= 1'b0;
    in_item_i <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_tokens[k]) begin
      row          = directed_tokens[k];
      it.operation = row.op;
      it.value     = row.val;
      send_token(it);
      if (row.nref != 0) begin
        for (int i = 0; i < row.nref; i++) begin
          expected_bytes.push_back('{out_byte: row.ref_bytes[8*(row.nref-1-i) +: 8],
                                     last: (i == row.nref - 1)});
        end
      end else begin
        encode_token(it);
      end
      maybe_pause_sender();
    end

    for (int k = 0; k < RandomTokens; k++) begin
      calm = (k >= RandomTokens - CalmTokens);
      if ($urandom_range(0, 19) < 18) begin
        it.operation = 4'($urandom_range(OP_INT, OP_PAYLOAD));
      end else begin
        it.operation = 4'($urandom_range(OpUnusedLo, OpUnusedHi));
      end
      it.value = rand_value();
      send_token(it);
      encode_token(it);
      maybe_pause_sender();
    end
    push <= 1'b0;

    while (expected_bytes.size() != 0) @(posedge clk_i);
    // unused codes are dropped at the queue input and must stay silent
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : watchdog
    #(TimeoutNs);
    $display("FAILURE");
    $finish;
  end

endmodule

// File: sim.f
design/cbor_enc_pkg.sv
design/cbor_enc_front.sv
design/cbor_enc_queue.sv
design/cbor_enc_back.sv
design/cbor_item_head_encoder_top.sv
tb/sv/cbor_item_head_encoder_top_tb.sv
